>>> sv/dqs_pkg.sv
// shared types and codes for the bounded deque with first-match search
`default_nettype none

package dqs_pkg;

  localparam int COMMAND_W   = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int POS_W       = 7;

  typedef logic [COMMAND_W-1:0]       cmd_t;
  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [COUNT_OUT_W-1:0]     count_out_t;
  typedef logic signed [POS_W-1:0]    pos_t;

  // command codes
  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_FIND       = 3'd4;

  // status codes
  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  // no match found, or not a search
  localparam pos_t POS_NONE = 7'sh7F;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

endpackage

`default_nettype wire

>>> sv/dqs_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/deque_with_first_match_search.sv
// top level: bounded ring deque with a sequential first-match search
// push, pop and unused commands give their result in the cycle after the transfer;
//   so does a search on an empty store
// a search compares k entries, k = first match offset + 1 or the held count, so up to CAPACITY;
//   each entry is read from the ram, then compared; one ram read and one 32-bit compare per cycle
// busy stays high during a search; pushes and pops take a new command every cycle
// reset clears the front pointer, the count and the sequencer; storage is not cleared
// results are strobed by done for one cycle and cannot be stalled
`default_nettype none

module deque_with_first_match_search #(
  parameter int CAPACITY = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire dqs_pkg::cmd_t       command,
  input  wire dqs_pkg::value_t     value,
  output logic                     busy,
  output logic                     done,
  output dqs_pkg::status_t         status,
  output dqs_pkg::count_out_t      entry_count,
  output dqs_pkg::pos_t            match_position
);

  import dqs_pkg::*;

  // ring pointer, count and ring-sum widths
  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  localparam logic [PW-1:0] LAST_PTR = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);

  // sequencer and deque state
  state_t        state, state_next;
  logic [PW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;

  // search walk: read side and compare side of the ram pipeline
  value_t        value_q;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] rd_off;
  logic          cmp_valid;
  logic [PW-1:0] cmp_off;

  // ram hookup
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic          ram_re;
  logic [VALUE_W-1:0] ram_rdata;

  logic          accept;
  logic          full, empty;
  logic [PW-1:0] front_dec, front_inc;
  logic [SW-1:0] back_sum, back_wrap;
  logic [PW-1:0] back_ptr;
  logic          hit, last;

  // result being formed this cycle
  logic          res_fire;
  status_t       res_status;
  pos_t          res_pos;

  assign busy   = (state != ST_IDLE) | rst;
  assign accept = start & ~busy;

  assign full  = (count == CAP_C);
  assign empty = (count == '0);

  // ring neighbors of the front entry
  assign front_dec = (front == '0) ? LAST_PTR : front - PW'(1);
  assign front_inc = (front == LAST_PTR) ? '0 : front + PW'(1);

  // slot after the back entry: front + count, one conditional subtract wraps it
  assign back_sum  = SW'(front) + SW'(count);
  assign back_wrap = (back_sum >= CAP_S) ? back_sum - CAP_S : back_sum;
  assign back_ptr  = back_wrap[PW-1:0];

  // read the next offset only while offsets are left
  assign ram_re = (state == ST_SEARCH) && (rd_off < count);

  // compare stage sees the entry read in the previous cycle
  assign hit  = cmp_valid && (ram_rdata == VALUE_W'($unsigned(value_q)));
  assign last = cmp_valid && ((CW'(cmp_off) + CW'(1)) == count);

  // pushes write the ram only when there is room
  assign ram_we    = accept && !full &&
                     ((command == CMD_PUSH_FRONT) || (command == CMD_PUSH_BACK));
  assign ram_waddr = (command == CMD_PUSH_FRONT) ? front_dec : back_ptr;

  dqs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(VALUE_W'($unsigned(value))),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  // sequencer: immediate updates in idle, entry walk in search
  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    res_fire   = 1'b0;
    res_status = STATUS_DONE;
    res_pos    = POS_NONE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_fire = 1'b1;
          case (command)
            CMD_PUSH_FRONT: begin
              if (full) begin
                res_status = STATUS_FULL;
              end else begin
                front_next = front_dec;
                count_next = count + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                res_status = STATUS_FULL;
              end else begin
                count_next = count + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                res_status = STATUS_EMPTY;
              end else begin
                front_next = front_inc;
                count_next = count - CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                res_status = STATUS_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            CMD_FIND: begin
              // empty store answers at once with no match
              if (!empty) begin
                res_fire   = 1'b0;
                state_next = ST_SEARCH;
              end
            end
            default: begin
              // unused codes leave the store alone
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          res_fire   = 1'b1;
          res_pos    = POS_W'(cmp_off);
          state_next = ST_IDLE;
        end else if (last) begin
          res_fire   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      front     <= '0;
      count     <= '0;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      done      <= res_fire;
      cmp_valid <= ram_re;
    end
  end

  // search walk and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      value_q <= value;
      rd_ptr  <= front;
      rd_off  <= '0;
    end else if (ram_re) begin
      rd_ptr  <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      rd_off  <= rd_off + CW'(1);
    end
    if (ram_re) begin
      cmp_off <= rd_off[PW-1:0];
    end
    if (res_fire) begin
      status         <= res_status;
      entry_count    <= COUNT_OUT_W'(count_next);
      match_position <= res_pos;
    end
  end

  // the held count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("held count above capacity");

  // no result shows while a search is still walking
  a_quiet_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> !done)
    else $error("result strobe during search");

  // every non-search command answers on the next cycle
  a_quick_reply: assert property (@(posedge clk) disable iff (rst)
    (accept && (command != CMD_FIND)) |=> done)
    else $error("missing one-cycle result");

  // a pop on an empty store is flagged
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && ((command == CMD_POP_FRONT) || (command == CMD_POP_BACK)))
      |=> (done && (status == STATUS_EMPTY) && (count == '0)))
    else $error("pop on empty store not flagged");

  // a refused or failed operation never reports a position
  a_pos_none: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STATUS_DONE)) |-> (match_position == POS_NONE))
    else $error("position reported with error status");

endmodule

`default_nettype wire
